// ===== rtl/core/dcm_pkg.sv =====
`timescale 1ns / 1ps
package dcm_pkg;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_VOLTAGE = 2'd1;
  localparam logic [1:0] KIND_CURRENT = 2'd2;
  localparam logic [1:0] KIND_STALL   = 2'd3;

  localparam logic [2:0] CFG_R      = 3'd0;
  localparam logic [2:0] CFG_KN     = 3'd1;
  localparam logic [2:0] CFG_PPR    = 3'd2;
  localparam logic [2:0] CFG_SCALE  = 3'd3;
  localparam logic [2:0] CFG_THRESH = 3'd4;
  localparam logic [2:0] CFG_HOLD   = 3'd5;

  localparam logic [15:0] R_RESET      = 16'd1000;
  localparam logic [15:0] KN_RESET     = 16'd100;
  localparam logic [15:0] PPR_RESET    = 16'd2048;
  localparam logic [15:0] SCALE_RESET  = 16'd100;
  localparam logic [15:0] THRESH_RESET = 16'd15600;
  localparam logic [7:0]  HOLD_RESET   = 8'd25;

  localparam logic [15:0] TWO_PI_MILLI = 16'd6283;
  localparam logic [15:0] MILLI        = 16'd1000;
  localparam logic [15:0] BEMF_GAIN    = 16'd10;
  localparam logic [31:0] STALL_RATIO  = 32'd2;

  localparam int DIV_STEPS = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS_GO, ST_POS_WT, ST_SPD, ST_BEMF_GO, ST_BEMF_WT,
    ST_CUR_GO, ST_CUR_WT, ST_CMD_GO, ST_CMD_WT, ST_STL_GO, ST_STL_WT,
    ST_STL2_GO, ST_STL2_WT, ST_OUT
  } dcm_state_t;

  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } dcm_div_req_t;

endpackage

// ===== rtl/core/dc_motor_state_estimator.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       in         in_valid / in_stall       kind, pulse_count, duty_millivolt, command_value
// out      out        out_valid / out_stall     position .. shutdown_request
// cfg      in         cfg_write_en              cfg_index, cfg_data
//
// One beat in, one beat out. A voltage command or a held stall check goes straight to
// the result beat; every other item runs through one shared 32x16 multiplier and one
// radix-2 divider.
// Reset is synchronous on rst and loads the register defaults.
// in_stall is high from acceptance until the result beat is taken; the result
// holds on the output ports while out_stall is high.
module dc_motor_state_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] pulse_count,
  input  logic [15:0]        duty_millivolt,
  input  logic signed [15:0] command_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position_millirad,
  output logic signed [31:0] speed_millirad_s,
  output logic signed [31:0] accel_value,
  output logic signed [31:0] current_estimate_ma,
  output logic signed [15:0] drive_millivolt,
  output logic               shutdown_request,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  dcm_pkg::dcm_state_t   state, state_next;
  dcm_pkg::dcm_div_req_t div_req;
  logic                  div_done;
  logic [31:0]           div_q;

  // configuration
  logic [15:0] cfg_r, cfg_kn, cfg_ppr, cfg_scale, cfg_thresh;
  logic [7:0]  cfg_hold;

  // estimator state
  logic [31:0] pulse_total, position, speed, accel, current, abs_speed;
  logic [15:0] voltage, duty;
  logic        shutdown;
  logic [7:0]  hold_count;

  // held item and intermediates
  logic [1:0]  kind_q;
  logic [15:0] pulses_q, cmd_q;
  logic [31:0] bemf, ratio_tmp;

  // shared multiplier
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] mul_p;

  logic        accept;
  logic [8:0]  hold_inc;
  logic [31:0] volt_sum;

  assign mul_p    = mul_a * {16'd0, mul_b};
  assign accept   = in_valid && (state == dcm_pkg::ST_IDLE);
  assign hold_inc = {1'b0, hold_count} + 9'd1;
  assign volt_sum = div_q + bemf;

  dcm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r      <= dcm_pkg::R_RESET;
      cfg_kn     <= dcm_pkg::KN_RESET;
      cfg_ppr    <= dcm_pkg::PPR_RESET;
      cfg_scale  <= dcm_pkg::SCALE_RESET;
      cfg_thresh <= dcm_pkg::THRESH_RESET;
      cfg_hold   <= dcm_pkg::HOLD_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        dcm_pkg::CFG_R:      cfg_r      <= cfg_data;
        dcm_pkg::CFG_KN:     cfg_kn     <= cfg_data;
        dcm_pkg::CFG_PPR:    cfg_ppr    <= cfg_data;
        dcm_pkg::CFG_SCALE:  cfg_scale  <= cfg_data;
        dcm_pkg::CFG_THRESH: cfg_thresh <= cfg_data;
        dcm_pkg::CFG_HOLD:   cfg_hold   <= cfg_data[7:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, multiplier operands and divider requests
  always_comb begin
    state_next        = state;
    mul_a             = '0;
    mul_b             = '0;
    div_req.start     = 1'b0;
    div_req.is_signed = 1'b1;
    div_req.dividend  = mul_p;
    div_req.divisor   = '0;
    case (state)
      dcm_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (kind)
            dcm_pkg::KIND_TICK:    state_next = dcm_pkg::ST_POS_GO;
            dcm_pkg::KIND_VOLTAGE: state_next = dcm_pkg::ST_OUT;
            dcm_pkg::KIND_CURRENT: state_next = dcm_pkg::ST_BEMF_GO;
            default: state_next = shutdown ? dcm_pkg::ST_OUT : dcm_pkg::ST_STL_GO;
          endcase
        end
      end
      dcm_pkg::ST_POS_GO: begin
        mul_a           = pulse_total;
        mul_b           = dcm_pkg::TWO_PI_MILLI;
        div_req.start   = 1'b1;
        div_req.divisor = cfg_ppr;
        state_next      = dcm_pkg::ST_POS_WT;
      end
      dcm_pkg::ST_POS_WT: if (div_done) state_next = dcm_pkg::ST_SPD;
      dcm_pkg::ST_SPD: begin
        mul_a      = {{16{pulses_q[15]}}, pulses_q};
        mul_b      = cfg_scale;
        state_next = dcm_pkg::ST_BEMF_GO;
      end
      dcm_pkg::ST_BEMF_GO: begin
        mul_a           = speed;
        mul_b           = dcm_pkg::BEMF_GAIN;
        div_req.start   = 1'b1;
        div_req.divisor = cfg_kn;
        state_next      = dcm_pkg::ST_BEMF_WT;
      end
      dcm_pkg::ST_BEMF_WT: begin
        if (div_done) begin
          state_next = (kind_q == dcm_pkg::KIND_TICK) ? dcm_pkg::ST_CUR_GO : dcm_pkg::ST_CMD_GO;
        end
      end
      dcm_pkg::ST_CUR_GO: begin
        mul_a           = {{16{voltage[15]}}, voltage} - bemf;
        mul_b           = dcm_pkg::MILLI;
        div_req.start   = 1'b1;
        div_req.divisor = cfg_r;
        state_next      = dcm_pkg::ST_CUR_WT;
      end
      dcm_pkg::ST_CUR_WT: if (div_done) state_next = dcm_pkg::ST_OUT;
      dcm_pkg::ST_CMD_GO: begin
        mul_a           = {{16{cmd_q[15]}}, cmd_q};
        mul_b           = cfg_r;
        div_req.start   = 1'b1;
        div_req.divisor = dcm_pkg::MILLI;
        state_next      = dcm_pkg::ST_CMD_WT;
      end
      dcm_pkg::ST_CMD_WT: if (div_done) state_next = dcm_pkg::ST_OUT;
      dcm_pkg::ST_STL_GO: begin
        mul_a             = abs_speed;
        mul_b             = dcm_pkg::MILLI;
        div_req.start     = 1'b1;
        div_req.is_signed = 1'b0;
        div_req.divisor   = cfg_kn;
        state_next        = dcm_pkg::ST_STL_WT;
      end
      dcm_pkg::ST_STL_WT: if (div_done) state_next = dcm_pkg::ST_STL2_GO;
      dcm_pkg::ST_STL2_GO: begin
        div_req.start     = 1'b1;
        div_req.is_signed = 1'b0;
        div_req.dividend  = ratio_tmp;
        div_req.divisor   = duty;
        state_next        = dcm_pkg::ST_STL2_WT;
      end
      dcm_pkg::ST_STL2_WT: if (div_done) state_next = dcm_pkg::ST_OUT;
      dcm_pkg::ST_OUT: if (!out_stall) state_next = dcm_pkg::ST_IDLE;
      default: state_next = dcm_pkg::ST_IDLE;
    endcase
  end

  // datapath updates, one step per sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_total <= '0;
      position    <= '0;
      speed       <= '0;
      accel       <= '0;
      current     <= '0;
      abs_speed   <= '0;
      voltage     <= '0;
      duty        <= '0;
      shutdown    <= 1'b0;
      hold_count  <= '0;
    end else begin
      case (state)
        dcm_pkg::ST_IDLE: begin
          if (accept) begin
            case (kind)
              dcm_pkg::KIND_TICK: begin
                pulse_total <= pulse_total + {{16{pulse_count[15]}}, pulse_count};
                duty        <= duty_millivolt;
              end
              dcm_pkg::KIND_VOLTAGE: voltage <= command_value;
              dcm_pkg::KIND_CURRENT: ;
              default: begin
                // count up a held shutdown and release it at cfg_hold
                if (shutdown) begin
                  if (hold_inc >= {1'b0, cfg_hold}) begin
                    hold_count <= '0;
                    shutdown   <= 1'b0;
                  end else begin
                    hold_count <= hold_inc[7:0];
                  end
                end
              end
            endcase
          end
        end
        dcm_pkg::ST_POS_WT: if (div_done) position <= div_q;
        dcm_pkg::ST_SPD: begin
          speed     <= mul_p;
          accel     <= mul_p - speed;
          abs_speed <= mul_p[31] ? (32'd0 - mul_p) : mul_p;
        end
        dcm_pkg::ST_CUR_WT: if (div_done) current <= div_q;
        dcm_pkg::ST_CMD_WT: begin
          if (div_done) begin
            // saturate the drive voltage to 16 bits
            if (!volt_sum[31] && (volt_sum > 32'sd32767)) begin
              voltage <= 16'h7fff;
            end else if (volt_sum[31] && (volt_sum < 32'hffff8000)) begin
              voltage <= 16'h8000;
            end else begin
              voltage <= volt_sum[15:0];
            end
          end
        end
        dcm_pkg::ST_STL2_WT: begin
          if (div_done && (div_q <= dcm_pkg::STALL_RATIO) && (duty > cfg_thresh)) begin
            shutdown <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // item hold and intermediates
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      pulses_q <= pulse_count;
      cmd_q    <= command_value;
    end
    if ((state == dcm_pkg::ST_BEMF_WT) && div_done) begin
      bemf <= div_q;
    end
    if ((state == dcm_pkg::ST_STL_WT) && div_done) begin
      ratio_tmp <= div_q;
    end
  end

  assign in_stall            = (state != dcm_pkg::ST_IDLE);
  assign out_valid           = (state == dcm_pkg::ST_OUT);
  assign position_millirad   = position;
  assign speed_millirad_s    = speed;
  assign accel_value         = accel;
  assign current_estimate_ma = current;
  assign drive_millivolt     = voltage;
  assign shutdown_request    = shutdown;

endmodule

// ===== rtl/core/dcm_divider.sv =====
`timescale 1ns / 1ps
module dcm_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  dcm_pkg::dcm_div_req_t req,
  output logic                 done,
  output logic [31:0]          quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dv;
  logic        neg;
  logic [16:0] trial;
  logic        fits;

  // restoring step: one quotient bit a cycle
  assign trial = {rem, quo[31]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(dcm_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.is_signed && req.dividend[31];
      quo <= (req.is_signed && req.dividend[31]) ? (32'd0 - req.dividend) : req.dividend;
      rem <= '0;
      dv  <= req.divisor;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, dv}) : trial[15:0];
      quo <= {quo[30:0], fits};
    end
  end

  // zero divisor yields zero
  assign quotient = (dv == 16'd0) ? 32'd0 : (neg ? (32'd0 - quo) : quo);

  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a run");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider still busy at done");

endmodule

// ===== dv/dcm_checker.sv =====
`timescale 1ns / 1ps
module dcm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] pulse_count,
  input  logic [15:0]        duty_millivolt,
  input  logic signed [15:0] command_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] position_millirad,
  input  logic signed [31:0] speed_millirad_s,
  input  logic signed [31:0] accel_value,
  input  logic signed [31:0] current_estimate_ma,
  input  logic signed [15:0] drive_millivolt,
  input  logic               shutdown_request,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] spd;
    logic [31:0] acc;
    logic [31:0] cur;
    logic [15:0] drv;
    logic        shut;
  } motor_obs_t;

  motor_obs_t obs_q[$];

  logic [31:0] r_ohm, kn, ppr, scale, thresh, hold;
  logic [31:0] pulse_sum, pos_m, spd_m, acc_m, cur_m, abs_spd;
  logic [15:0] volt_m, duty_m;
  logic        shut_m;
  logic [7:0]  hold_cnt;

  assign pending = obs_q.size();

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] d);
    if (d == 0) return 32'd0;
    return 32'($signed(a) / $signed({1'b0, d}));
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic advance_model(logic [1:0] k, logic [15:0] p, logic [15:0] d,
                               logic [15:0] c);
    logic [31:0] prev, v, ratio;
    logic [32:0] cnt;
    case (k)
      dcm_pkg::KIND_TICK: begin
        prev = spd_m;
        pulse_sum = pulse_sum + sx16(p);
        pos_m = div_trunc(pulse_sum * 32'd6283, ppr);
        spd_m = sx16(p) * scale;
        acc_m = spd_m - prev;
        cur_m = div_trunc((sx16(volt_m) - div_trunc(spd_m * 32'd10, kn)) * 32'd1000,
                          r_ohm);
        duty_m = d;
        abs_spd = spd_m[31] ? -spd_m : spd_m;
      end
      dcm_pkg::KIND_VOLTAGE: volt_m = c;
      dcm_pkg::KIND_CURRENT: begin
        v = div_trunc(r_ohm * sx16(c), 32'd1000) + div_trunc(spd_m * 32'd10, kn);
        if ($signed(v) > 32767) volt_m = 16'h7fff;
        else if ($signed(v) < -32768) volt_m = 16'h8000;
        else volt_m = v[15:0];
      end
      default: begin
        if (shut_m) begin
          cnt = hold_cnt + 33'd1;
          if (cnt >= hold) begin
            hold_cnt = 0;
            shut_m = 0;
          end else begin
            hold_cnt = cnt[7:0];
          end
        end else begin
          ratio = 32'hffffffff;
          if (kn != 0 && duty_m != 0) ratio = ((abs_spd * 32'd1000) / kn) / duty_m;
          else if (duty_m != 0) ratio = 0;
          if (ratio <= 2 && duty_m > thresh) shut_m = 1;
        end
      end
    endcase
    obs_q.push_back('{pos_m, spd_m, acc_m, cur_m, volt_m, shut_m});
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    motor_obs_t e;
    if (rst) begin
      r_ohm = dcm_pkg::R_RESET; kn = dcm_pkg::KN_RESET; ppr = dcm_pkg::PPR_RESET;
      scale = dcm_pkg::SCALE_RESET; thresh = dcm_pkg::THRESH_RESET;
      hold = dcm_pkg::HOLD_RESET;
      pulse_sum = 0; pos_m = 0; spd_m = 0; acc_m = 0; cur_m = 0; abs_spd = 0;
      volt_m = 0; duty_m = 0; shut_m = 0; hold_cnt = 0;
      obs_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          dcm_pkg::CFG_R:      r_ohm  = cfg_data;
          dcm_pkg::CFG_KN:     kn     = cfg_data;
          dcm_pkg::CFG_PPR:    ppr    = cfg_data;
          dcm_pkg::CFG_SCALE:  scale  = cfg_data;
          dcm_pkg::CFG_THRESH: thresh = cfg_data;
          dcm_pkg::CFG_HOLD:   hold   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        advance_model(kind, pulse_count, duty_millivolt, command_value);
      if (out_valid && !out_stall) begin
        if (obs_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = obs_q.pop_front();
          check_field("position_millirad", e.pos, position_millirad);
          check_field("speed_millirad_s", e.spd, speed_millirad_s);
          check_field("accel_value", e.acc, accel_value);
          check_field("current_estimate_ma", e.cur, current_estimate_ma);
          check_field("drive_millivolt", {16'd0, e.drv}, {16'd0, drive_millivolt});
          check_field("shutdown_request", 32'(e.shut), 32'(shutdown_request));
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic signed [15:0] pulse_count;
  logic [15:0]        duty_millivolt;
  logic signed [15:0] command_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] position_millirad;
  logic signed [31:0] speed_millirad_s;
  logic signed [31:0] accel_value;
  logic signed [31:0] current_estimate_ma;
  logic signed [15:0] drive_millivolt;
  logic               shutdown_request;
  logic               cfg_write_en;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 pending;
  bit                 sink_quiet;

  dc_motor_state_estimator dut (.*);

  dcm_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Ample bound: ~1800 beats plus random idle gaps on both sides.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Result side: draw a stall length per beat, sometimes run flat out.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Send one beat, waiting out a random gap first unless told not to.
  task automatic send_beat(logic [1:0] k, logic [15:0] p, logic [15:0] d,
                           logic [15:0] c, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    pulse_count    <= p;
    duty_millivolt <= d;
    command_value  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, drain every outstanding result, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Random motor traffic: random kinds with extra stall checks and high-duty beats so shutdowns trigger.
  task automatic random_beats(int count);
    logic [1:0] k;
    bit burst;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      k = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: send_beat(k, 16'($urandom), 16'($urandom), 16'($urandom), burst);
        1: send_beat(k, 16'($signed($urandom_range(0, 20)) - 10),
                     16'($urandom_range(15000, 65535)), 16'($urandom), burst);
        2: send_beat(dcm_pkg::KIND_STALL, 16'($urandom), 16'($urandom), 16'($urandom),
                     burst);
        default: send_beat(k, 16'($urandom), 16'($urandom_range(0, 3)),
                           16'($urandom), burst);
      endcase
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = dcm_pkg::KIND_TICK;
    pulse_count    = '0;
    duty_millivolt = '0;
    command_value  = '0;
    cfg_write_en   = 1'b0;
    cfg_index      = dcm_pkg::CFG_R;
    cfg_data       = '0;
    sink_quiet     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes on defaults, every kind, stall trigger and hold.
    send_beat(dcm_pkg::KIND_TICK, 16'h7fff, 16'hffff, 16'h0000);
    send_beat(dcm_pkg::KIND_TICK, 16'h8000, 16'h0000, 16'h0000);
    send_beat(dcm_pkg::KIND_VOLTAGE, 16'h0000, 16'h0000, 16'h7fff);
    send_beat(dcm_pkg::KIND_TICK, 16'h0001, 16'hffff, 16'h0000);
    send_beat(dcm_pkg::KIND_CURRENT, 16'h0000, 16'h0000, 16'h7fff);
    send_beat(dcm_pkg::KIND_CURRENT, 16'h0000, 16'h0000, 16'h8000);
    send_beat(dcm_pkg::KIND_VOLTAGE, 16'h0000, 16'h0000, 16'h8000);
    send_beat(dcm_pkg::KIND_STALL, 16'h0000, 16'h0000, 16'h0000);
    repeat (27) send_beat(dcm_pkg::KIND_STALL, 16'h0000, 16'h0000, 16'h0000);
    send_beat(dcm_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_beat(dcm_pkg::KIND_STALL, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // Zero divisors and zero hold; unused index is ignored.
    write_reg(dcm_pkg::CFG_R, 16'd0);
    write_reg(dcm_pkg::CFG_KN, 16'd0);
    write_reg(dcm_pkg::CFG_PPR, 16'd0);
    write_reg(dcm_pkg::CFG_SCALE, 16'd0);
    write_reg(dcm_pkg::CFG_THRESH, 16'd0);
    write_reg(dcm_pkg::CFG_HOLD, 16'd0);
    write_reg(3'd7, 16'hffff);
    send_beat(dcm_pkg::KIND_TICK, 16'h0005, 16'h0010, 16'h0000);
    send_beat(dcm_pkg::KIND_CURRENT, 16'h0000, 16'h0000, 16'h1234);
    send_beat(dcm_pkg::KIND_STALL, 16'h0000, 16'h0000, 16'h0000);
    send_beat(dcm_pkg::KIND_STALL, 16'h0000, 16'h0000, 16'h0000);
    random_beats(150);
    drain();

    // Top of range.
    write_reg(dcm_pkg::CFG_R, 16'hffff);
    write_reg(dcm_pkg::CFG_KN, 16'hffff);
    write_reg(dcm_pkg::CFG_PPR, 16'hffff);
    write_reg(dcm_pkg::CFG_SCALE, 16'hffff);
    write_reg(dcm_pkg::CFG_THRESH, 16'hffff);
    write_reg(dcm_pkg::CFG_HOLD, 16'h00ff);
    random_beats(150);
    drain();

    // Random settings, with a quiet sink phase for back-to-back beats.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(dcm_pkg::CFG_R, 16'($urandom_range(1, 65535)));
      write_reg(dcm_pkg::CFG_KN, 16'($urandom_range(1, 2000)));
      write_reg(dcm_pkg::CFG_PPR, 16'($urandom_range(1, 65535)));
      write_reg(dcm_pkg::CFG_SCALE, 16'($urandom));
      write_reg(dcm_pkg::CFG_THRESH, 16'($urandom_range(0, 20000)));
      write_reg(dcm_pkg::CFG_HOLD, 16'($urandom_range(1, 8)));
      sink_quiet = (ph == 3);
      random_beats(160);
      drain();
    end
    sink_quiet = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dcm_pkg.sv
rtl/core/dcm_divider.sv
rtl/core/dc_motor_state_estimator.sv
dv/dcm_checker.sv
dv/tb_top.sv
